>>> rtl/core/sca_pkg.sv
// Shared types, codes and size-class tables for the size-class block allocator.
// No dependencies.
`timescale 1ns / 1ps
package sca_pkg;

  localparam int SIZE_CLASSES  = 16;
  localparam int CLASS_W       = 4;
  localparam int LARGEST_BLOCK = 640;
  localparam int BYTES_W       = 10;

  // Request kinds
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_IGNORED   = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  // Command to the class head file
  typedef struct packed {
    logic                 clear;
    logic                 wr;
    logic [CLASS_W-1:0]   cls;
  } sca_head_cmd_t;

  function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLASS_W-1:0] cls);
    logic [BYTES_W-1:0] b;
    case (cls)
      4'd0:    b = 10'd4;
      4'd1:    b = 10'd8;
      4'd2:    b = 10'd16;
      4'd3:    b = 10'd32;
      4'd4:    b = 10'd64;
      4'd5:    b = 10'd96;
      4'd6:    b = 10'd128;
      4'd7:    b = 10'd160;
      4'd8:    b = 10'd192;
      4'd9:    b = 10'd224;
      4'd10:   b = 10'd256;
      4'd11:   b = 10'd320;
      4'd12:   b = 10'd384;
      4'd13:   b = 10'd448;
      4'd14:   b = 10'd512;
      default: b = 10'd640;
    endcase
    return b;
  endfunction

  // Smallest class that holds size; size is known to be at most the largest block.
  function automatic logic [CLASS_W-1:0] pick_class(input logic [BYTES_W-1:0] size);
    logic [CLASS_W-1:0] c;
    c = CLASS_W'(SIZE_CLASSES - 1);
    for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
      if (class_bytes(CLASS_W'(i)) >= size) c = CLASS_W'(i);
    end
    return c;
  endfunction

endpackage

>>> rtl/core/sca_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sca_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/sca_heads.sv
// Per-class free-list head registers with valid bits and a one-cycle clear.
// Depends on sca_pkg.
`timescale 1ns / 1ps
module sca_heads #(
  parameter int AW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sca_pkg::sca_head_cmd_t cmd,
  input  logic [AW:0]            wr_entry,
  input  logic [3:0]             rd_cls,
  output logic [AW:0]            rd_entry
);
  import sca_pkg::*;

  logic [SIZE_CLASSES-1:0] valid;
  logic [AW-1:0]           head_addr [SIZE_CLASSES];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= '0;
    end else if (cmd.wr) begin
      valid[cmd.cls] <= wr_entry[AW];
    end
    if (cmd.wr) head_addr[cmd.cls] <= wr_entry[AW-1:0];
  end

  // Empty entries read as end of list
  assign rd_entry = valid[rd_cls] ? {1'b1, head_addr[rd_cls]} : '0;

endmodule

>>> rtl/core/size_class_block_allocator.sv
// Top level of the size-class block allocator: sequencer, shared address adder,
// pool fill pointer and result register. Depends on sca_pkg, sca_ram, sca_heads.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; its single result
// appears on granted_address and status for exactly one cycle with done high,
// and the receiver cannot stall it, so capture it in that cycle. Clear, free and
// rejected requests finish from the decode state, an allocation served from a
// free list passes from decode through the pop state (one registered read of
// the link memory), and an allocation that carves a fresh page walks the page
// in the carve state with one link write per cycle through the single write
// port of the link memory using one shared address adder.
// busy drops in the done cycle, so the next request may be presented there.
// The link memory has no reset; only links written by a carve or a free are
// ever followed.
module size_class_block_allocator #(
  parameter int PAGE_BLOCKS = 16,
  parameter int POOL_BYTES  = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [23:0] request_size,
  input  logic [15:0] block_address,
  output logic        done,
  output logic [15:0] granted_address,
  output logic [1:0]  status
);
  import sca_pkg::*;

  localparam int LW    = $clog2(POOL_BYTES / 4);   // link index width
  localparam int AW    = LW + 2;                   // pool byte address width
  localparam int FW    = AW + 1;                   // fill pointer, holds POOL_BYTES
  localparam int CW    = 21;                       // page and room compare width
  localparam int CNT_W = $clog2(PAGE_BLOCKS);
  localparam logic [CW-1:0]    POOL_CW  = CW'(POOL_BYTES);
  localparam logic [CNT_W-1:0] LAST_BLK = CNT_W'(PAGE_BLOCKS - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_POP    = 2'd2;
  localparam logic [1:0] S_CARVE  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       item_kind;
  logic [23:0]      item_size;
  logic [AW-1:0]    item_addr;
  logic             item_in_pool;
  logic [FW-1:0]    fill;
  logic [FW-1:0]    cur;
  logic [AW-1:0]    base;
  logic [AW-1:0]    first_next;
  logic [CNT_W-1:0] cnt;
  logic [AW-1:0]    granted;

  logic [AW+15:0]   addr_pad;
  logic [AW+15:0]   grant_pad;
  logic [CLASS_W-1:0] cls;
  logic [BYTES_W-1:0] bs;
  logic [CW-1:0]    page;
  logic [CW-1:0]    room;
  logic             exhausted;
  logic             size_zero;
  logic             too_big;
  logic [FW-1:0]    sum;
  logic             last_blk;

  sca_head_cmd_t    head_cmd;
  logic [AW:0]      head_wr;
  logic [AW:0]      head_rd;

  logic             ram_we;
  logic [LW-1:0]    ram_waddr;
  logic [AW:0]      ram_wdata;
  logic [AW:0]      ram_rdata;

  // Decode the held request
  assign size_zero = (item_size == 24'd0);
  assign too_big   = (item_size > 24'(LARGEST_BLOCK));
  assign cls       = pick_class(item_size[BYTES_W-1:0]);
  assign bs        = class_bytes(cls);
  assign page      = CW'(bs) * CW'(PAGE_BLOCKS);
  assign room      = POOL_CW - CW'(fill);
  assign exhausted = (page > room);

  // Shared address adder: steps the carve walk and yields the new fill
  assign sum      = cur + FW'(bs);
  assign last_blk = (cnt == LAST_BLK);

  assign addr_pad        = {{AW{1'b0}}, block_address};
  assign grant_pad       = {16'd0, granted};
  assign granted_address = grant_pad[15:0];
  assign busy            = (state != S_IDLE);

  sca_heads #(.AW(AW)) u_heads (
    .clk      (clk),
    .rst      (rst),
    .cmd      (head_cmd),
    .wr_entry (head_wr),
    .rd_cls   (cls),
    .rd_entry (head_rd)
  );

  sca_ram #(.WIDTH(AW + 1), .DEPTH(POOL_BYTES / 4)) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_rd[AW-1:2]),
    .rdata (ram_rdata)
  );

  // Head file and link memory write controls
  always_comb begin
    head_cmd  = '0;
    head_cmd.cls = cls;
    head_wr   = {1'b1, item_addr};
    ram_we    = 1'b0;
    ram_waddr = item_addr[AW-1:2];
    ram_wdata = head_rd;
    case (state)
      S_DECODE: begin
        if (item_kind == KIND_CLEAR) begin
          head_cmd.clear = 1'b1;
        end else if (item_kind == KIND_FREE && !size_zero && !too_big && item_in_pool) begin
          // Push: link the freed block to the old head, make it the head
          ram_we      = 1'b1;
          head_cmd.wr = 1'b1;
        end
      end
      S_POP: begin
        // Advance the head to the popped block's successor
        head_cmd.wr = 1'b1;
        head_wr     = ram_rdata;
      end
      S_CARVE: begin
        ram_we    = 1'b1;
        ram_waddr = cur[AW-1:2];
        ram_wdata = last_blk ? '0 : {1'b1, sum[AW-1:0]};
        if (last_blk) begin
          head_cmd.wr = 1'b1;
          head_wr     = {1'b1, first_next};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      fill  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            item_kind    <= kind;
            item_size    <= request_size;
            item_addr    <= {addr_pad[AW-1:2], 2'b00};
            item_in_pool <= (CW'(block_address) < POOL_CW);
            state        <= S_DECODE;
          end
        end
        S_DECODE: begin
          granted <= '0;
          status  <= ST_OK;
          state   <= S_IDLE;
          done    <= 1'b1;
          if (item_kind == KIND_CLEAR) begin
            fill <= '0;
          end else if (item_kind == KIND_NONE || size_zero) begin
            status <= ST_IGNORED;
          end else if (too_big) begin
            status <= ST_TOO_LARGE;
          end else if (item_kind == KIND_ALLOC) begin
            if (head_rd[AW]) begin
              // Pop: link read is in flight, finish next cycle
              granted <= head_rd[AW-1:0];
              done    <= 1'b0;
              state   <= S_POP;
            end else if (exhausted) begin
              status <= ST_EXHAUSTED;
            end else begin
              // Carve a fresh page starting at the fill pointer
              cur   <= fill;
              base  <= fill[AW-1:0];
              cnt   <= '0;
              done  <= 1'b0;
              state <= S_CARVE;
            end
          end
        end
        S_POP: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_CARVE: begin
          cur <= sum;
          cnt <= cnt + CNT_W'(1);
          if (cnt == '0) first_next <= sum[AW-1:0];
          if (last_blk) begin
            fill    <= sum;
            granted <= base;
            done    <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/tb_top.sv
// Testbench for size_class_block_allocator: directed and random allocate, free
// and clear requests, checked against a free-list tracker class. Depends on sca_pkg.
`timescale 1ns / 1ps
module tb_top;
  import sca_pkg::*;

  localparam int PAGE_BLOCKS  = 16;
  localparam int POOL_BYTES   = 65536;
  localparam int LINK_WORDS   = POOL_BYTES / 4;
  localparam int RANDOM_ITEMS = 1700;
  // The limit bounds the whole run; the slowest item is a carve plus a sender gap.
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [15:0] addr;
    logic [1:0]  status;
  } grant_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [23:0] size;
  } held_block_t;

  // Mirror of the class heads, the link memory and the pool bump pointer.
  // Each accepted item updates the mirror and queues the result it must give.
  class free_list_tracker;
    int unsigned block_bytes[SIZE_CLASSES] = '{4, 8, 16, 32, 64, 96, 128, 160,
                                               192, 224, 256, 320, 384, 448, 512, 640};
    bit          head_valid[SIZE_CLASSES];
    logic [15:0] head_addr[SIZE_CLASSES];
    bit          link_valid[LINK_WORDS];
    logic [15:0] link_addr[LINK_WORDS];
    int unsigned pool_fill;
    grant_t      grants_due[$];
    int          mismatch_count;

    function new();
      foreach (head_valid[i]) head_valid[i] = 1'b0;
      pool_fill      = 0;
      mismatch_count = 0;
    endfunction

    function int unsigned class_of(logic [23:0] size);
      int unsigned c;
      c = 0;
      while (c < SIZE_CLASSES - 1 && block_bytes[c] < size) c++;
      return c;
    endfunction

    function grant_t note_request(logic [1:0] req_kind, logic [23:0] req_size,
                                  logic [15:0] req_addr);
      grant_t      g;
      int unsigned c;
      int unsigned bs;
      int unsigned page;
      int unsigned base;
      int unsigned word;
      logic [15:0] blk;
      g.addr   = '0;
      g.status = ST_OK;
      blk      = {req_addr[15:2], 2'b00};
      if (req_kind == KIND_CLEAR) begin
        foreach (head_valid[i]) head_valid[i] = 1'b0;
        pool_fill = 0;
      end else if (req_kind == KIND_NONE || req_size == 0) begin
        g.status = ST_IGNORED;
      end else if (req_size > LARGEST_BLOCK) begin
        g.status = ST_TOO_LARGE;
      end else begin
        c = class_of(req_size);
        if (req_kind == KIND_FREE) begin
          // Every 16-bit address lies inside the pool, so each free is pushed.
          link_valid[blk[15:2]] = head_valid[c];
          link_addr[blk[15:2]]  = head_addr[c];
          head_valid[c] = 1'b1;
          head_addr[c]  = blk;
        end else if (head_valid[c]) begin
          g.addr        = head_addr[c];
          head_valid[c] = link_valid[g.addr[15:2]];
          head_addr[c]  = link_addr[g.addr[15:2]];
        end else begin
          bs   = block_bytes[c];
          page = bs * PAGE_BLOCKS;
          if (page > POOL_BYTES - pool_fill) begin
            g.status = ST_EXHAUSTED;
          end else begin
            base = pool_fill;
            for (int i = 0; i < PAGE_BLOCKS; i++) begin
              word             = (base + i * bs) / 4;
              link_valid[word] = (i < PAGE_BLOCKS - 1);
              link_addr[word]  = 16'(base + (i + 1) * bs);
            end
            head_valid[c] = 1'b1;
            head_addr[c]  = 16'(base + bs);
            pool_fill     = pool_fill + page;
            g.addr        = 16'(base);
          end
        end
      end
      grants_due.push_back(g);
      return g;
    endfunction

    task flag_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 100) $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task check_grant(logic [15:0] got_addr, logic [1:0] got_status);
      grant_t want;
      if (grants_due.size() == 0) begin
        flag_mismatch($sformatf("result addr %h status %0d with nothing outstanding",
                                got_addr, got_status));
      end else begin
        want = grants_due.pop_front();
        if (got_status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", got_status, want.status));
        if (got_addr !== want.addr)
          flag_mismatch($sformatf("granted_address %h, expected %h", got_addr, want.addr));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  kind = KIND_ALLOC;
  logic [23:0] request_size = '0;
  logic [15:0] block_address = '0;
  logic        busy;
  logic        done;
  logic [15:0] granted_address;
  logic [1:0]  status;

  free_list_tracker sb;
  held_block_t      held_blocks[$];
  int unsigned      burst_left = 0;
  bit               steady_phase = 1'b0;
  int unsigned      cycles = 0;

  size_class_block_allocator #(
    .PAGE_BLOCKS(PAGE_BLOCKS),
    .POOL_BYTES (POOL_BYTES)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .request_size   (request_size),
    .block_address  (block_address),
    .done           (done),
    .granted_address(granted_address),
    .status         (status)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Results cannot be stalled: take each one in its done cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_grant(granted_address, status);
  end

  // Present one item and hold it until taken. Bursts of random length are
  // separated by random gaps with start low, unless the phase runs steady.
  task present(logic [1:0] req_kind, logic [23:0] req_size, logic [15:0] req_addr);
    grant_t g;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady_phase) repeat ($urandom_range(1, 7)) @(negedge clk) start <= 1'b0;
    end
    burst_left--;
    @(negedge clk);
    start         <= 1'b1;
    kind          <= req_kind;
    request_size  <= req_size;
    block_address <= req_addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    g = sb.note_request(req_kind, req_size, req_addr);
    if (req_kind == KIND_ALLOC && g.status == ST_OK) held_blocks.push_back('{g.addr, req_size});
    else if (req_kind == KIND_CLEAR) held_blocks.delete();
  endtask

  // Size that maps to class c: its top edge, its bottom edge or anything between.
  function automatic logic [23:0] size_in_class(int unsigned c);
    int unsigned lo;
    lo = (c == 0) ? 1 : sb.block_bytes[c - 1] + 1;
    case ($urandom_range(0, 3))
      0:       return 24'(sb.block_bytes[c]);
      1:       return 24'(lo);
      default: return 24'($urandom_range(lo, sb.block_bytes[c]));
    endcase
  endfunction

  task run_directed();
    int unsigned carve_sizes[10] = '{640, 449, 448, 321, 320, 256, 193, 192, 129, 128};
    present(KIND_ALLOC, 24'd0, 16'h0000);
    present(KIND_FREE, 24'd0, 16'hFFFF);
    present(KIND_NONE, 24'd4, 16'h0004);
    present(KIND_ALLOC, 24'd641, 16'h0000);
    present(KIND_ALLOC, 24'hFFFFFF, 16'hFFFF);
    present(KIND_FREE, 24'd641, 16'h0040);
    // Carve a page in each of the ten largest classes, each at its top or bottom edge.
    foreach (carve_sizes[i]) present(KIND_ALLOC, 24'(carve_sizes[i]), 16'h0000);
    // Free the 640-byte head, misaligned, into the empty 4-byte class: its link
    // now reads end of list, so one pop empties the 640 list and the next carves.
    present(KIND_FREE, 24'd1, sb.head_addr[15] | 16'h0003);
    present(KIND_ALLOC, 24'd640, 16'h0000);
    present(KIND_ALLOC, 24'd639, 16'h0000);
    // Same trick on the 512 list; the pool is then too short for its page.
    present(KIND_FREE, 24'd5, sb.head_addr[14]);
    present(KIND_ALLOC, 24'd512, 16'h0000);
    present(KIND_ALLOC, 24'd500, 16'h0000);
    // Top address, then a double free pushed twice.
    present(KIND_FREE, 24'd4, 16'hFFFF);
    present(KIND_ALLOC, 24'd3, 16'h0000);
    present(KIND_FREE, 24'd8, 16'h0100);
    present(KIND_FREE, 24'd8, 16'h0100);
    present(KIND_ALLOC, 24'd7, 16'h0000);
    present(KIND_CLEAR, 24'hFFFFFF, 16'hFFFF);
    present(KIND_ALLOC, 24'd4, 16'h0000);
  endtask

  // Phases of mostly well-formed traffic: allocate, then free what was granted,
  // with some wrong sizes, misaligned addresses, double and stray frees, and noise.
  task run_random();
    int unsigned counted;
    int unsigned top_class;
    int unsigned r;
    int unsigned idx;
    held_block_t hb;
    logic [23:0] sz;
    logic [15:0] ad;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      steady_phase = ($urandom_range(0, 3) == 0);
      top_class    = ($urandom_range(0, 2) == 0) ? SIZE_CLASSES - 1 : $urandom_range(0, 7);
      repeat ($urandom_range(40, 160)) begin
        r = $urandom_range(0, 99);
        if (r < 45 || (r < 75 && held_blocks.size() == 0)) begin
          present(KIND_ALLOC, size_in_class($urandom_range(0, top_class)), 16'($urandom));
          counted++;
        end else if (r < 75) begin
          idx = $urandom_range(0, held_blocks.size() - 1);
          hb  = held_blocks[idx];
          // Leave one in ten on the held list so it gets freed twice.
          if ($urandom_range(0, 9) != 0) held_blocks.delete(idx);
          sz = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(1, LARGEST_BLOCK)) : hb.size;
          ad = hb.addr | 16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
          present(KIND_FREE, sz, ad);
          counted++;
        end else if (r < 80) begin
          present(KIND_FREE, 24'($urandom_range(1, LARGEST_BLOCK)), 16'($urandom));
          counted++;
        end else if (r < 95) begin
          case ($urandom_range(0, 3))
            0: present($urandom_range(0, 1) ? KIND_FREE : KIND_ALLOC, 24'd0, 16'($urandom));
            1: present($urandom_range(0, 1) ? KIND_FREE : KIND_ALLOC,
                       24'($urandom_range(LARGEST_BLOCK + 1, 24'hFFFFFF)), 16'($urandom));
            2: present(KIND_ALLOC, 24'($urandom), 16'($urandom));
            default: present(KIND_NONE, 24'($urandom), 16'($urandom));
          endcase
          counted++;
        end else if (r < 96) begin
          present(KIND_CLEAR, 24'($urandom), 16'($urandom));
          counted++;
        end else begin
          present(KIND_ALLOC, 24'($urandom_range(1, LARGEST_BLOCK)), 16'($urandom));
          counted++;
        end
      end
      if ($urandom_range(0, 1) == 0) present(KIND_CLEAR, 24'd0, 16'h0000);
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    @(negedge clk) start <= 1'b0;
    // Drain, then watch a while longer for stray results.
    while (sb.grants_due.size() != 0) @(posedge clk);
    repeat (PAGE_BLOCKS + 8) @(posedge clk);
    if (sb.mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
